[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLT_ASSERT(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define MLT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MLT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MLT_ASSERT(name, clk, rst_n, expr)
`define MLT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define MLT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/mlt_pkg.sv]
// ----------------------------------------------------------------------------
// mlt_pkg
// Types, character codes and classifier helpers for the line tokenizer.
// ----------------------------------------------------------------------------
package mlt_pkg;

	localparam int GRP_N = 5;
	localparam logic [2:0] GRP_MAX = 3'd5;
	localparam int GQ_DEPTH = 4;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;

	localparam logic [7:0] BT_PARA  = 8'd0;
	localparam logic [7:0] BT_HEAD  = 8'd1;
	localparam logic [7:0] BT_LIST  = 8'd2;
	localparam logic [7:0] BT_QUOTE = 8'd3;

	typedef enum logic [2:0] {
		TK_WCHAR  = 3'd0,
		TK_WEND   = 3'd1,
		TK_PUNCT  = 3'd2,
		TK_SBEGIN = 3'd3,
		TK_SEND   = 3'd4,
		TK_BSTART = 3'd5,
		TK_BEND   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		BLK_NONE  = 3'd0,
		BLK_PARA  = 3'd1,
		BLK_HEAD  = 3'd2,
		BLK_LIST  = 3'd3,
		BLK_QUOTE = 3'd4
	} blk_t;

	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_HASH = 2'd1,
		PH_MARK = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} tok_t;

	typedef struct packed {
		tok_t [GRP_N-1:0] tok;
		logic [2:0]       cnt;
	} group_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
			((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic is_stop(logic [7:0] c);
		return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUEST);
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return is_stop(c) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) ||
			(c == CH_DASH);
	endfunction

	function automatic logic [7:0] blk_code(blk_t b);
		logic [7:0] r;
		unique case (b)
			BLK_HEAD:  r = BT_HEAD;
			BLK_LIST:  r = BT_LIST;
			BLK_QUOTE: r = BT_QUOTE;
			default:   r = BT_PARA;
		endcase
		return r;
	endfunction

	function automatic group_t add_tok(group_t g, kind_t k, logic [7:0] v);
		group_t r;
		r = g;
		if (g.cnt < GRP_MAX) begin
			r.tok[g.cnt].kind = k;
			r.tok[g.cnt].value = v;
			r.cnt = g.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

[hw/rtl/mlt_front.sv]
// ----------------------------------------------------------------------------
// mlt_front
// Line classifier and tokenizer: turns one byte into a group of tokens.
// ----------------------------------------------------------------------------
module mlt_front #(
	parameter int MAX_WORD = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  logic            operation,
	input  logic [7:0]      ch,
	output logic            grp_push,
	output mlt_pkg::group_t grp
);
	import mlt_pkg::*;

	localparam int WL = (MAX_WORD > 2) ? $clog2(MAX_WORD) : 1;
	localparam logic [WL-1:0] WL_LIMIT = WL'(MAX_WORD - 1);

	typedef struct packed {
		logic set_en;
		blk_t set_val;
		logic dash_en;
		logic wend_en;
		logic cont_en;
		logic eol;
		logic eod;
	} act_t;

	phase_t        ph_q, ph_nxt;
	blk_t          blk_q, blk_nxt;
	logic          sp_q, sp_nxt;
	logic          dsh_q, dsh_nxt;
	logic          iw_q, iw_nxt;
	logic [WL-1:0] wl_q, wl_nxt;
	act_t          act;
	group_t        g;

	// next phase and actions
	always_comb begin
		act = '0;
		act.set_val = BLK_NONE;
		ph_nxt = ph_q;
		dsh_nxt = dsh_q;
		if (operation || (ch == CH_NL)) begin
			act.eol = 1'b1;
			act.eod = operation;
			ph_nxt = PH_LEAD;
			dsh_nxt = 1'b0;
			unique case (ph_q)
				PH_LEAD: begin
					act.set_en = 1'b1;
					act.set_val = BLK_NONE;
				end
				PH_HASH: begin
					act.set_en = 1'b1;
					act.set_val = BLK_PARA;
				end
				PH_MARK: begin
					act.set_en = 1'b1;
					act.set_val = BLK_LIST;
					act.dash_en = dsh_q;
				end
				PH_BODY: act.wend_en = iw_q;
			endcase
		end else begin
			unique case (ph_q)
				PH_LEAD: begin
					if (is_ws(ch)) begin
					end else if (ch == CH_HASH) begin
						ph_nxt = PH_HASH;
					end else if (ch == CH_DASH || ch == CH_STAR || ch == CH_PLUS) begin
						ph_nxt = PH_MARK;
						dsh_nxt = (ch == CH_DASH);
					end else begin
						act.set_en = 1'b1;
						act.set_val = (ch == CH_GT) ? BLK_QUOTE : BLK_PARA;
						act.cont_en = 1'b1;
						ph_nxt = PH_BODY;
					end
				end
				PH_HASH: begin
					if (ch != CH_HASH) begin
						act.set_en = 1'b1;
						act.set_val = is_ws(ch) ? BLK_HEAD : BLK_PARA;
						act.cont_en = 1'b1;
						ph_nxt = PH_BODY;
					end
				end
				PH_MARK: begin
					if (!is_ws(ch)) begin
						act.set_en = 1'b1;
						act.set_val = is_alnum(ch) ? BLK_LIST : BLK_PARA;
						act.dash_en = dsh_q;
						act.cont_en = 1'b1;
						dsh_nxt = 1'b0;
						ph_nxt = PH_BODY;
					end
				end
				PH_BODY: act.cont_en = 1'b1;
			endcase
		end
	end

	// token group and data state
	always_comb begin
		g = '0;
		blk_nxt = blk_q;
		sp_nxt = sp_q;
		iw_nxt = iw_q;
		wl_nxt = wl_q;
		if (act.set_en && (act.set_val != blk_nxt)) begin
			if (blk_nxt != BLK_NONE)
				g = add_tok(g, TK_BEND, 8'd0);
			if (act.set_val != BLK_NONE)
				g = add_tok(g, TK_BSTART, blk_code(act.set_val));
			blk_nxt = act.set_val;
			sp_nxt = 1'b1;
		end
		if (act.dash_en)
			g = add_tok(g, TK_PUNCT, CH_DASH);
		if (act.wend_en)
			g = add_tok(g, TK_WEND, 8'd0);
		if (act.cont_en) begin
			if (is_alnum(ch)) begin
				if (!iw_nxt) begin
					if (sp_nxt) begin
						g = add_tok(g, TK_SBEGIN, 8'd0);
						sp_nxt = 1'b0;
					end
					iw_nxt = 1'b1;
					wl_nxt = '0;
				end
				if (wl_nxt < WL_LIMIT) begin
					g = add_tok(g, TK_WCHAR, ch);
					wl_nxt = wl_nxt + WL'(1);
				end
			end else begin
				if (iw_nxt) begin
					g = add_tok(g, TK_WEND, 8'd0);
					iw_nxt = 1'b0;
					wl_nxt = '0;
				end
				if (is_punct(ch)) begin
					g = add_tok(g, TK_PUNCT, ch);
					if (is_stop(ch)) begin
						g = add_tok(g, TK_SEND, 8'd0);
						sp_nxt = 1'b1;
					end
				end
			end
		end
		if (act.eol) begin
			iw_nxt = 1'b0;
			wl_nxt = '0;
		end
		if (act.eod) begin
			if (blk_nxt != BLK_NONE)
				g = add_tok(g, TK_BEND, 8'd0);
			blk_nxt = BLK_NONE;
			sp_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LEAD;
			blk_q <= BLK_NONE;
			sp_q <= 1'b1;
			dsh_q <= 1'b0;
			iw_q <= 1'b0;
			wl_q <= '0;
		end else if (acc) begin
			ph_q <= ph_nxt;
			blk_q <= blk_nxt;
			sp_q <= sp_nxt;
			dsh_q <= dsh_nxt;
			iw_q <= iw_nxt;
			wl_q <= wl_nxt;
		end
	end

	assign grp = g;
	assign grp_push = acc && (g.cnt != 3'd0);

endmodule

[hw/rtl/mlt_gfifo.sv]
// ----------------------------------------------------------------------------
// mlt_gfifo
// Short queue of token groups between the tokenizer and the serializer.
// ----------------------------------------------------------------------------
module mlt_gfifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mlt_pkg::group_t din,
	output logic            full,
	input  logic            pop,
	output mlt_pkg::group_t dout,
	output logic            empty
);
	import mlt_pkg::*;

	localparam int PW = $clog2(GQ_DEPTH);

	group_t      mem_q [GQ_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full = (cnt_q == (PW+1)'(GQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= rptr_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

endmodule

[hw/rtl/mlt_back.sv]
// ----------------------------------------------------------------------------
// mlt_back
// Serializer: sends the tokens of each group one beat at a time.
// ----------------------------------------------------------------------------
module mlt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mlt_pkg::group_t grp,
	input  logic            grp_empty,
	output logic            grp_pop,
	input  logic            pop,
	output logic            empty,
	output logic [2:0]      token_kind,
	output logic [7:0]      token_value,
	output logic            last
);
	import mlt_pkg::*;

	logic [2:0] idx_q;
	logic       vld_q;
	logic [2:0] kind_q;
	logic [7:0] value_q;
	logic       last_q;
	logic       load, fin;

	assign load = !grp_empty && (!vld_q || pop);
	assign fin = (idx_q == (grp.cnt - 3'd1));
	assign grp_pop = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			vld_q <= load || (vld_q && !pop);
			if (load)
				idx_q <= fin ? 3'd0 : (idx_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= 3'(grp.tok[idx_q].kind);
			value_q <= grp.tok[idx_q].value;
			last_q <= fin;
		end
	end

	assign empty = !vld_q;
	assign token_kind = kind_q;
	assign token_value = value_q;
	assign last = last_q;

endmodule

[hw/rtl/markdown_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// markdown_line_tokenizer
// Streaming Markdown line classifier and word/punctuation tokenizer.
// ----------------------------------------------------------------------------
// One byte (or end-of-document) is taken per cycle; the tokenizer turns it
// into a group of zero to five tokens in that same cycle and drops the group
// into a four-entry queue. The serializer hands out one token per cycle while
// pop is held, so the input sustains one item per cycle as long as items
// average no more than one token each; an item with several tokens holds the
// output side until all are sent, and full rises only when the group queue is
// full. A token passes through the group queue and the serializer's output
// register before it shows on the output. The final token of each item carries last.
module markdown_line_tokenizer #(
	parameter int MAX_WORD = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       operation,
	input  logic [7:0] ch,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] token_kind,
	output logic [7:0] token_value,
	output logic       last
);
	import mlt_pkg::*;

	`include "assert_macros.svh"

	logic   acc;
	logic   g_push, g_full, g_pop, g_empty;
	group_t g_in, g_head;

	assign full = g_full;
	assign acc = push && !g_full;

	mlt_front #(
		.MAX_WORD(MAX_WORD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.operation(operation),
		.ch       (ch),
		.grp_push (g_push),
		.grp      (g_in)
	);

	mlt_gfifo u_gfifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (g_push),
		.din   (g_in),
		.full  (g_full),
		.pop   (g_pop),
		.dout  (g_head),
		.empty (g_empty)
	);

	mlt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp        (g_head),
		.grp_empty  (g_empty),
		.grp_pop    (g_pop),
		.pop        (pop),
		.empty      (empty),
		.token_kind (token_kind),
		.token_value(token_value),
		.last       (last)
	);

	`MLT_ASSERT(a_gq_sane, clk, arst_n, !(g_full && g_empty))
	`MLT_ASSERT_IMPL(a_head_nonzero, clk, arst_n, !g_empty, g_head.cnt != 3'd0)
	`MLT_ASSERT_NEXT(a_out_fills, clk, arst_n, empty && !g_empty, !empty)

endmodule

[sim/markdown_line_tokenizer_tb.sv]
// ----------------------------------------------------------------------------
// markdown_line_tokenizer_tb
// Self-checking bench for the line tokenizer. A short directed table walks
// the classifier corners, then random Markdown-like lines (headings, lists,
// quotes, paragraphs, blanks, noise) are streamed with bursty input and a
// stalling output side. Every popped token beat is checked against an
// in-bench token predictor, or against the tokens typed into a directed row.
// ----------------------------------------------------------------------------
module markdown_line_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlt_pkg::*;

	localparam int WORD_CAP  = 256;
	localparam int GRP_CAP   = 5;
	localparam int HOLD_CYC  = 80;
	localparam int DRAIN_CYC = 20;
	localparam int RAND_ITEMS = 250;
	localparam int DIR_N     = 29;

	localparam logic [7:0] CH_VT = 8'd11;
	localparam logic [7:0] CH_FF = 8'd12;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} due_t;

	typedef struct {
		logic       op;
		logic [7:0] c;
		int         nfix;
		tok_t       want [GRP_CAP];
	} dir_row_t;

	localparam tok_t NIL = '{TK_WCHAR, 8'd0};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       operation = 1'b0;
	logic [7:0] ch = 8'd0;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] token_kind;
	logic [7:0] token_value;
	logic       last;

	markdown_line_tokenizer #(
		.MAX_WORD(WORD_CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.ch(ch),
		.empty(empty),
		.pop(pop),
		.token_kind(token_kind),
		.token_value(token_value),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// directed walk; nfix >= 0 means the tokens are typed in here
	dir_row_t dir_tab [DIR_N] = '{
		'{1'b1, 8'h00,    0, '{default: NIL}},
		'{1'b0, CH_UA,    3, '{'{TK_BSTART, BT_PARA}, '{TK_SBEGIN, 8'd0},
			'{TK_WCHAR, CH_UA}, NIL, NIL}},
		'{1'b0, CH_LZ,   -1, '{default: NIL}},
		'{1'b0, CH_DOT,   3, '{'{TK_WEND, 8'd0}, '{TK_PUNCT, CH_DOT},
			'{TK_SEND, 8'd0}, NIL, NIL}},
		'{1'b0, 8'hff,    0, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_HASH, -1, '{default: NIL}},
		'{1'b0, CH_HASH, -1, '{default: NIL}},
		'{1'b0, CH_SPACE, -1, '{default: NIL}},
		'{1'b0, CH_9,    -1, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_DASH, -1, '{default: NIL}},
		'{1'b0, CH_TAB,  -1, '{default: NIL}},
		'{1'b0, 8'h78,    5, '{'{TK_BEND, 8'd0}, '{TK_BSTART, BT_LIST},
			'{TK_PUNCT, CH_DASH}, '{TK_SBEGIN, 8'd0}, '{TK_WCHAR, 8'h78}}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_PLUS, -1, '{default: NIL}},
		'{1'b0, CH_BANG, -1, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_GT,   -1, '{default: NIL}},
		'{1'b0, CH_COMMA, -1, '{default: NIL}},
		'{1'b0, CH_QUEST, -1, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_NL,    1, '{'{TK_BEND, 8'd0}, NIL, NIL, NIL, NIL}},
		'{1'b0, CH_HASH, -1, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_DASH, -1, '{default: NIL}},
		'{1'b0, CH_NL,   -1, '{default: NIL}},
		'{1'b0, CH_LA,   -1, '{default: NIL}},
		'{1'b1, 8'hff,    2, '{'{TK_WEND, 8'd0}, '{TK_BEND, 8'd0}, NIL, NIL, NIL}}
	};

	// predictor state
	blk_t        cur_blk;
	logic        sent_open;
	phase_t      ln_phase;
	logic        dash_mark;
	logic        in_word;
	int unsigned wlen;
	tok_t        grp_q [$];

	due_t tok_due_q [$];
	due_t due_head;
	int   err_cnt = 0;
	int   fix_row = -1;
	int   sent_cnt = 0;
	int   burst_left = 0;
	int   long_left = 2;
	logic steady = 1'b0;
	logic hold_req = 1'b0;

	function automatic logic ws_byte(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic alnum_byte(logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
			((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic stop_byte(logic [7:0] c);
		return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUEST);
	endfunction

	function automatic logic punct_byte(logic [7:0] c);
		return stop_byte(c) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) ||
			(c == CH_DASH);
	endfunction

	function automatic void put(kind_t k, logic [7:0] v);
		if (grp_q.size() < GRP_CAP)
			grp_q.push_back('{k, v});
	endfunction

	function automatic void clear_state();
		cur_blk = BLK_NONE;
		sent_open = 1'b1;
		ln_phase = PH_LEAD;
		dash_mark = 1'b0;
		in_word = 1'b0;
		wlen = 0;
	endfunction

	function automatic void switch_block(blk_t nb);
		if (nb != cur_blk) begin
			if (cur_blk != BLK_NONE)
				put(TK_BEND, 8'd0);
			if (nb != BLK_NONE)
				put(TK_BSTART, 8'(nb) - 8'd1);
			cur_blk = nb;
			sent_open = 1'b1;
		end
	endfunction

	function automatic void body_byte(logic [7:0] c);
		if (alnum_byte(c)) begin
			if (!in_word) begin
				if (sent_open) begin
					put(TK_SBEGIN, 8'd0);
					sent_open = 1'b0;
				end
				in_word = 1'b1;
				wlen = 0;
			end
			if (wlen < WORD_CAP - 1) begin
				put(TK_WCHAR, c);
				wlen++;
			end
		end else begin
			if (in_word) begin
				put(TK_WEND, 8'd0);
				in_word = 1'b0;
				wlen = 0;
			end
			if (punct_byte(c)) begin
				put(TK_PUNCT, c);
				if (stop_byte(c)) begin
					put(TK_SEND, 8'd0);
					sent_open = 1'b1;
				end
			end
		end
	endfunction

	function automatic void close_line();
		if (ln_phase == PH_LEAD) begin
			switch_block(BLK_NONE);
		end else if (ln_phase == PH_HASH) begin
			switch_block(BLK_PARA);
		end else if (ln_phase == PH_MARK) begin
			switch_block(BLK_LIST);
			if (dash_mark)
				put(TK_PUNCT, CH_DASH);
		end else if (in_word) begin
			put(TK_WEND, 8'd0);
		end
		ln_phase = PH_LEAD;
		dash_mark = 1'b0;
		in_word = 1'b0;
		wlen = 0;
	endfunction

	function automatic void tokenize_byte(logic [7:0] c);
		if (c == CH_NL) begin
			close_line();
		end else begin
			case (ln_phase)
				PH_LEAD: begin
					if (!ws_byte(c)) begin
						if (c == CH_HASH) begin
							ln_phase = PH_HASH;
						end else if (c == CH_DASH || c == CH_STAR || c == CH_PLUS) begin
							ln_phase = PH_MARK;
							dash_mark = (c == CH_DASH);
						end else begin
							switch_block((c == CH_GT) ? BLK_QUOTE : BLK_PARA);
							ln_phase = PH_BODY;
							body_byte(c);
						end
					end
				end
				PH_HASH: begin
					if (c != CH_HASH) begin
						switch_block(ws_byte(c) ? BLK_HEAD : BLK_PARA);
						ln_phase = PH_BODY;
						body_byte(c);
					end
				end
				PH_MARK: begin
					if (!ws_byte(c)) begin
						switch_block(alnum_byte(c) ? BLK_LIST : BLK_PARA);
						if (dash_mark)
							body_byte(CH_DASH);
						dash_mark = 1'b0;
						ln_phase = PH_BODY;
						body_byte(c);
					end
				end
				default: body_byte(c);
			endcase
		end
	endfunction

	function automatic void tokenize_item(logic op, logic [7:0] c);
		grp_q.delete();
		if (op) begin
			close_line();
			switch_block(BLK_NONE);
			clear_state();
		end else begin
			tokenize_byte(c);
		end
	endfunction

	// accept side and check side share one process, so the order is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				tokenize_item(operation, ch);
				if (fix_row >= 0) begin
					grp_q.delete();
					for (int i = 0; i < dir_tab[fix_row].nfix; i++)
						grp_q.push_back(dir_tab[fix_row].want[i]);
				end
				foreach (grp_q[i])
					tok_due_q.push_back('{grp_q[i].kind, grp_q[i].value,
						(i == grp_q.size() - 1)});
			end
			if (pop && !empty) begin
				if (tok_due_q.size() == 0) begin
					$error("unexpected beat: token_kind %0d token_value 0x%02h",
						token_kind, token_value);
					err_cnt++;
				end else begin
					due_head = tok_due_q.pop_front();
					if (token_kind !== due_head.kind) begin
						$error("token_kind: expected %0d, got %0d", due_head.kind, token_kind);
						err_cnt++;
					end
					if (token_value !== due_head.value) begin
						$error("token_value: expected 0x%02h, got 0x%02h",
							due_head.value, token_value);
						err_cnt++;
					end
					if (last !== due_head.last) begin
						$error("last: expected %0d, got %0d", due_head.last, last);
						err_cnt++;
					end
				end
			end
		end
	end

	// receiver: stall pattern in runs, plus one long hold-off on request
	initial begin
		int run_left;
		int mode;
		run_left = 0;
		mode = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
				hold_req <= 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 3);
					run_left = $urandom_range(5, 60);
				end
				run_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 3) != 0);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// one beat on the input, bursts and gaps around it
	task automatic offer(input logic op, input logic [7:0] c, input int row);
		if (!steady) begin
			if (burst_left == 0) begin
				push <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(10, 25)) @(negedge clk);
				else
					repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
		end
		fix_row = row;
		push <= 1'b1;
		operation <= op;
		ch <= c;
		do begin
			@(posedge clk);
		end while (full);
		sent_cnt++;
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		wait (tok_due_q.size() == 0);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rnd_alnum();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return CH_0 + 8'(r);
		else if (r < 36)
			return CH_LA + 8'(r - 10);
		else
			return CH_UA + 8'(r - 36);
	endfunction

	function automatic logic [7:0] rnd_ws();
		case ($urandom_range(0, 5))
			0: return CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] rnd_punct();
		case ($urandom_range(0, 6))
			0: return CH_DOT;
			1: return CH_COMMA;
			2: return CH_BANG;
			3: return CH_QUEST;
			4: return CH_SEMI;
			5: return CH_COLON;
			default: return CH_DASH;
		endcase
	endfunction

	function automatic logic [7:0] rnd_marker();
		case ($urandom_range(0, 2))
			0: return CH_DASH;
			1: return CH_STAR;
			default: return CH_PLUS;
		endcase
	endfunction

	task automatic send_text();
		int nw;
		int len;
		logic [7:0] b;
		nw = $urandom_range(1, 5);
		for (int w = 0; w < nw; w++) begin
			if (long_left > 0 && $urandom_range(0, 3) == 0) begin
				// around the word-length cap
				len = $urandom_range(WORD_CAP - 2, WORD_CAP + 44);
				long_left--;
			end else begin
				len = $urandom_range(1, 8);
			end
			repeat (len) offer(1'b0, rnd_alnum(), -1);
			case ($urandom_range(0, 7))
				0, 1, 2: offer(1'b0, CH_SPACE, -1);
				3, 4: begin
					offer(1'b0, rnd_punct(), -1);
					if ($urandom_range(0, 1))
						offer(1'b0, CH_SPACE, -1);
				end
				5: offer(1'b0, rnd_ws(), -1);
				6: begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_NL)
						b = 8'd0;
					offer(1'b0, b, -1);
				end
				default: repeat ($urandom_range(1, 3)) offer(1'b0, rnd_punct(), -1);
			endcase
		end
	endtask

	task automatic send_line();
		case ($urandom_range(0, 11))
			0: repeat ($urandom_range(0, 3)) offer(1'b0, rnd_ws(), -1);
			1, 2: begin
				repeat ($urandom_range(1, 3)) offer(1'b0, CH_HASH, -1);
				offer(1'b0, rnd_ws(), -1);
				send_text();
			end
			3, 4: begin
				offer(1'b0, rnd_marker(), -1);
				repeat ($urandom_range(0, 2)) offer(1'b0, rnd_ws(), -1);
				send_text();
			end
			5: begin
				offer(1'b0, CH_GT, -1);
				if ($urandom_range(0, 1))
					offer(1'b0, CH_SPACE, -1);
				send_text();
			end
			6, 7, 8: begin
				if ($urandom_range(0, 2) == 0)
					offer(1'b0, rnd_ws(), -1);
				send_text();
			end
			9: begin
				// malformed openings
				case ($urandom_range(0, 3))
					0: begin
						repeat ($urandom_range(1, 2)) offer(1'b0, CH_HASH, -1);
						offer(1'b0, $urandom_range(0, 1) ? rnd_alnum() : rnd_punct(), -1);
						send_text();
					end
					1: begin
						offer(1'b0, rnd_marker(), -1);
						repeat ($urandom_range(0, 1)) offer(1'b0, rnd_ws(), -1);
						offer(1'b0, rnd_punct(), -1);
						send_text();
					end
					2: begin
						offer(1'b0, rnd_marker(), -1);
						repeat ($urandom_range(0, 2)) offer(1'b0, rnd_ws(), -1);
					end
					default: repeat ($urandom_range(1, 4)) offer(1'b0, CH_HASH, -1);
				endcase
			end
			default: repeat ($urandom_range(1, 8)) offer(1'b0, 8'($urandom_range(0, 255)), -1);
		endcase
		if ($urandom_range(0, 11) == 0)
			offer(1'b1, 8'($urandom_range(0, 255)), -1);
		else
			offer(1'b0, CH_NL, -1);
		if ($urandom_range(0, 15) == 0)
			offer(1'b1, 8'($urandom_range(0, 255)), -1);
	endtask

	initial begin
		int rand_goal;
		logic paused;
		clear_state();
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			offer(dir_tab[i].op, dir_tab[i].c, (dir_tab[i].nfix >= 0) ? i : -1);
		settle();

		rand_goal = sent_cnt + RAND_ITEMS;
		// fill the block while the receiver holds off
		hold_req <= 1'b1;
		steady = 1'b1;
		do begin
			send_line();
		end while (hold_req);
		steady = 1'b0;
		while (sent_cnt < rand_goal) begin
			send_line();
			if (!paused && sent_cnt >= rand_goal - RAND_ITEMS / 2) begin
				settle();
				paused = 1'b1;
			end
		end

		settle();
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("markdown_line_tokenizer_tb: done, clean");
		else
			$display("markdown_line_tokenizer_tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("markdown_line_tokenizer_tb: done, errors");
		$finish;
	end

endmodule
